### hw/rtl/csog_pkg.sv
// Shared types and constants for the circle span and outline generator.
// Holds the walk widths, input codes and the control record that travels
// from the front part through the job queue to the back part.
package csog_pkg;

	// Default width of a centre coordinate.
	localparam int COORD_BITS_DEF = 16;

	// Fixed widths of the radius, the walk registers and the decision term.
	localparam int RADIUS_BITS = 15;
	localparam int WALK_BITS   = 17;
	localparam int TERM_BITS   = 20;

	// Depth of the job queue between the front and the back part.
	localparam int JOB_FIFO_DEPTH = 2;

	// Input operation codes.
	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	// Draw mode codes.
	localparam logic MODE_OUTLINE = 1'b0;
	localparam logic MODE_FILL    = 1'b1;

	// What a queued job expands into.
	typedef enum logic [1:0] {
		JOB_SPAN,
		JOB_POINT,
		JOB_NONE
	} job_kind_t;

	// Control part of one job: kind, index of its last result, done on last.
	typedef struct packed {
		job_kind_t   kind;
		logic [1:0]  last_idx;
		logic        done;
	} job_ctrl_t;

	localparam int JOB_CTRL_BITS = $bits(job_ctrl_t);

endpackage

### hw/rtl/csog_front.sv
// Front part of the circle span and outline generator: draw mode register,
// walk state and the per-item classification into queued jobs.
// Depends on csog_pkg.
module csog_front import csog_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_data,
	input  logic                          accept,
	input  logic                          operation,
	input  logic signed [COORD_BITS-1:0]  center_x,
	input  logic signed [COORD_BITS-1:0]  center_y,
	input  logic [RADIUS_BITS-1:0]        radius,
	output logic                          job_push,
	output job_ctrl_t                     job_ctrl,
	output logic signed [COORD_BITS-1:0]  job_cx,
	output logic signed [COORD_BITS-1:0]  job_cy,
	output logic signed [WALK_BITS-1:0]   job_x,
	output logic signed [WALK_BITS-1:0]   job_y
);

	localparam int EXT = TERM_BITS + 2;
	localparam logic signed [EXT-1:0] E_ONE   = EXT'(1);
	localparam logic signed [EXT-1:0] E_THREE = EXT'(3);
	localparam logic signed [EXT-1:0] E_FIVE  = EXT'(5);
	localparam logic signed [TERM_BITS-1:0] T_ONE = TERM_BITS'(1);
	localparam logic signed [TERM_BITS-1:0] T_TWO = TERM_BITS'(2);

	logic                          mode_q;
	logic                          busy_q, busy_d;
	logic                          fill_q, fill_d;
	logic signed [COORD_BITS-1:0]  cx_q, cx_d, cy_q, cy_d;
	logic signed [WALK_BITS-1:0]   x_q, x_d, y_q, y_d;
	logic signed [TERM_BITS-1:0]   t_q, t_d;

	logic signed [WALK_BITS-1:0]   r_walk;
	logic signed [TERM_BITS-1:0]   r_term;
	logic signed [EXT-1:0]         xe, ye, te;
	logic signed [EXT-1:0]         f_x, f_y, f_t;
	logic signed [WALK_BITS-1:0]   fx_w, fy_w;
	logic signed [TERM_BITS-1:0]   ft_w;
	logic                          o_c1, o_c2;
	logic signed [EXT-1:0]         o_y1, o_t1, o_x2, o_t2;
	logic signed [WALK_BITS-1:0]   ox_w, oy_w;
	logic signed [TERM_BITS-1:0]   ot_w;

	// Draw mode register, written from the configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_OUTLINE;
		end else if (cfg_we) begin
			mode_q <= cfg_data;
		end
	end

	// Control state of the walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fill_q <= MODE_OUTLINE;
		end else begin
			busy_q <= busy_d;
			fill_q <= fill_d;
		end
	end

	// Centre and walk values; they are only read while a figure is running.
	always_ff @(posedge clk) begin
		cx_q <= cx_d;
		cy_q <= cy_d;
		x_q  <= x_d;
		y_q  <= y_d;
		t_q  <= t_d;
	end

	assign r_walk = WALK_BITS'(radius);
	assign r_term = TERM_BITS'(radius);
	assign xe     = EXT'(x_q);
	assign ye     = EXT'(y_q);
	assign te     = EXT'(t_q);

	// Fill walk: one midpoint decision update.
	always_comb begin
		if (t_q[TERM_BITS-1]) begin
			f_t = te + (xe <<< 1) + E_THREE;
			f_y = ye;
		end else begin
			f_t = te + ((xe - ye) <<< 1) + E_FIVE;
			f_y = ye - E_ONE;
		end
		f_x = xe + E_ONE;
	end

	assign fx_w = WALK_BITS'(f_x);
	assign fy_w = WALK_BITS'(f_y);
	assign ft_w = TERM_BITS'(f_t);

	// Outline walk: error term update, row first and then column.
	always_comb begin
		o_c1 = (te <= ye);
		o_y1 = o_c1 ? (ye + E_ONE) : ye;
		o_t1 = o_c1 ? (te + (o_y1 <<< 1) + E_ONE) : te;
		o_c2 = (te > xe) || (o_t1 > o_y1);
		o_x2 = o_c2 ? (xe + E_ONE) : xe;
		o_t2 = o_c2 ? (o_t1 + (o_x2 <<< 1) + E_ONE) : o_t1;
	end

	assign ox_w = WALK_BITS'(o_x2);
	assign oy_w = WALK_BITS'(o_y1);
	assign ot_w = TERM_BITS'(o_t2);

	// Classify the accepted item, update the walk and form the job.
	always_comb begin
		busy_d   = busy_q;
		fill_d   = fill_q;
		cx_d     = cx_q;
		cy_d     = cy_q;
		x_d      = x_q;
		y_d      = y_q;
		t_d      = t_q;
		job_push = 1'b0;
		job_ctrl = '{kind: JOB_NONE, last_idx: 2'd0, done: 1'b1};
		job_cx   = cx_q;
		job_cy   = cy_q;
		job_x    = x_q;
		job_y    = y_q;
		if (accept) begin
			if (operation == OP_START) begin
				busy_d = 1'b1;
				fill_d = mode_q;
				cx_d   = center_x;
				cy_d   = center_y;
				if (mode_q == MODE_FILL) begin
					x_d      = '0;
					y_d      = r_walk;
					t_d      = T_ONE - r_term;
					// The diameter span is a one-row span job on the centre row.
					job_push = (radius != '0);
					job_ctrl = '{kind: JOB_SPAN, last_idx: 2'd0, done: 1'b0};
					job_cx   = center_x;
					job_cy   = center_y;
					job_x    = r_walk;
					job_y    = '0;
				end else begin
					x_d = -r_walk;
					y_d = '0;
					t_d = T_TWO - (r_term <<< 1);
				end
			end else if (!busy_q) begin
				job_push = 1'b1;
			end else if (fill_q == MODE_FILL) begin
				x_d      = fx_w;
				y_d      = fy_w;
				t_d      = ft_w;
				job_push = 1'b1;
				if (fx_w > fy_w) begin
					busy_d = 1'b0;
				end else begin
					job_ctrl = '{kind: JOB_SPAN,
						last_idx: (fx_w != fy_w) ? 2'd3 : 2'd1, done: 1'b0};
					job_x    = fx_w;
					job_y    = fy_w;
				end
			end else begin
				x_d      = ox_w;
				y_d      = oy_w;
				t_d      = ot_w;
				job_push = 1'b1;
				job_ctrl = '{kind: JOB_POINT, last_idx: 2'd3, done: !ox_w[WALK_BITS-1]};
				if (!ox_w[WALK_BITS-1]) begin
					busy_d = 1'b0;
				end
			end
		end
	end

	// A start always leaves a figure running.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && operation == OP_START |=> busy_q)
		else $error("start did not leave the walk busy");

	// Span jobs carry one, two or four rows.
	a_span_count: assert property (@(posedge clk) disable iff (!arst_n)
		job_push && job_ctrl.kind == JOB_SPAN |-> job_ctrl.last_idx != 2'd2)
		else $error("span job with three rows");

endmodule

### hw/rtl/csog_job_fifo.sv
// Short register queue that holds jobs between the front and back parts.
// Generic in width and depth; depends on nothing else.
module csog_job_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// The fill count never passes the depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("job queue count out of range");

endmodule

### hw/rtl/csog_back.sv
// Back part of the circle span and outline generator: expands the head job
// into result beats in the output register, one per cycle unless it is held.
// Depends on csog_pkg.
module csog_back import csog_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             fifo_empty,
	input  logic [JOB_CTRL_BITS+2*COORD_BITS+2*WALK_BITS-1:0] head,
	output logic                                             fifo_pop,
	input  logic                                             pop,
	output logic                                             empty,
	output logic signed [COORD_BITS:0]                       span_row,
	output logic signed [COORD_BITS:0]                       span_left,
	output logic signed [COORD_BITS:0]                       span_right,
	output logic                                             no_pixels,
	output logic                                             figure_done,
	output logic                                             run_last
);

	localparam int OUT_W = COORD_BITS + 1;
	localparam int JW    = JOB_CTRL_BITS + 2 * COORD_BITS + 2 * WALK_BITS;

	job_ctrl_t                     h_ctrl;
	logic signed [COORD_BITS-1:0]  h_cx, h_cy;
	logic signed [WALK_BITS-1:0]   h_x, h_y;
	logic signed [OUT_W-1:0]       cxo, cyo, xo, yo;
	logic signed [OUT_W-1:0]       cy_py, cy_my, cy_px, cy_mx;
	logic signed [OUT_W-1:0]       cx_px, cx_mx, cx_py, cx_my;
	logic signed [OUT_W-1:0]       r_row, r_left, r_right;
	logic                          r_nop, r_done;
	logic [1:0]                    k_q;
	logic                          is_last, load;
	logic                          out_valid_q;

	// Unpack the head job.
	assign h_ctrl = job_ctrl_t'(head[JW-1 -: JOB_CTRL_BITS]);
	assign h_cx   = head[2*COORD_BITS+2*WALK_BITS-1 -: COORD_BITS];
	assign h_cy   = head[COORD_BITS+2*WALK_BITS-1 -: COORD_BITS];
	assign h_x    = head[2*WALK_BITS-1 -: WALK_BITS];
	assign h_y    = head[WALK_BITS-1:0];

	// Operands at output width; wrapping is modulo the output width.
	assign cxo = OUT_W'(h_cx);
	assign cyo = OUT_W'(h_cy);
	assign xo  = OUT_W'(h_x);
	assign yo  = OUT_W'(h_y);

	// The eight mirrored coordinates of the current walk point.
	assign cy_py = cyo + yo;
	assign cy_my = cyo - yo;
	assign cy_px = cyo + xo;
	assign cy_mx = cyo - xo;
	assign cx_px = cxo + xo;
	assign cx_mx = cxo - xo;
	assign cx_py = cxo + yo;
	assign cx_my = cxo - yo;

	assign is_last = (k_q == h_ctrl.last_idx);
	assign load    = !fifo_empty && (!out_valid_q || pop);
	assign fifo_pop = load && is_last;

	// Pick the result for the current beat index of the head job.
	always_comb begin
		r_row   = '0;
		r_left  = '0;
		r_right = '0;
		r_nop   = 1'b1;
		r_done  = 1'b1;
		case (h_ctrl.kind)
			JOB_SPAN: begin
				r_nop  = 1'b0;
				r_done = 1'b0;
				case (k_q)
					2'd0: begin r_row = cy_py; r_left = cx_mx; r_right = cx_px; end
					2'd1: begin r_row = cy_my; r_left = cx_mx; r_right = cx_px; end
					2'd2: begin r_row = cy_px; r_left = cx_my; r_right = cx_py; end
					default: begin r_row = cy_mx; r_left = cx_my; r_right = cx_py; end
				endcase
			end
			JOB_POINT: begin
				r_nop  = 1'b0;
				r_done = h_ctrl.done && is_last;
				case (k_q)
					2'd0: begin r_row = cy_py; r_left = cx_mx; r_right = cx_mx; end
					2'd1: begin r_row = cy_mx; r_left = cx_my; r_right = cx_my; end
					2'd2: begin r_row = cy_my; r_left = cx_px; r_right = cx_px; end
					default: begin r_row = cy_px; r_left = cx_py; r_right = cx_py; end
				endcase
			end
			default: begin
				r_nop  = 1'b1;
				r_done = 1'b1;
			end
		endcase
	end

	// Beat index within the head job and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				k_q <= is_last ? 2'd0 : k_q + 2'd1;
			end
			out_valid_q <= load || (out_valid_q && !pop);
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (load) begin
			span_row    <= r_row;
			span_left   <= r_left;
			span_right  <= r_right;
			no_pixels   <= r_nop;
			figure_done <= r_done;
			run_last    <= is_last;
		end
	end

	assign empty = !out_valid_q;

	// The beat index stays within the head job.
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		!fifo_empty |-> k_q <= h_ctrl.last_idx)
		else $error("beat index past the last result of the job");

	// With no job waiting the beat index is back at the start.
	a_k_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_empty |-> k_q == 2'd0)
		else $error("beat index not cleared with the queue empty");

	// An empty job gives one empty, done, last result.
	a_none_beat: assert property (@(posedge clk) disable iff (!arst_n)
		load && h_ctrl.kind == JOB_NONE |=> no_pixels && figure_done && run_last && !empty)
		else $error("empty job gave a wrong result");

endmodule

### hw/rtl/circle_span_and_outline_generator.sv
// Top level of the circle span and outline generator: front part, job queue
// and back part. Depends on csog_pkg, csog_front, csog_job_fifo and csog_back.
//
//  channel  | handshake         | beat
//  ---------+-------------------+---------------------------------------------
//  input    | push / full       | operation, center_x, center_y, radius
//  result   | empty / pop       | span_row, span_left, span_right, no_pixels,
//           |                   | figure_done, run_last
//  config   | cfg_we            | cfg_data (draw mode)
//
// The front takes one input beat per cycle while the two-entry job queue has room.
// The back gives one result beat per cycle unless the output is held, so a fill step
// gives two or four, an outline step four, a fill start one and an empty result one.
// An input beat's first result passes through the job queue and the output register.
// Reset clears the draw mode to outline, ends any figure and empties the queue.
// A stalled result side fills the queue, then full rises and holds the input.
module circle_span_and_outline_generator import csog_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_data,
	input  logic                          push,
	output logic                          full,
	input  logic                          operation,
	input  logic signed [COORD_BITS-1:0]  center_x,
	input  logic signed [COORD_BITS-1:0]  center_y,
	input  logic [RADIUS_BITS-1:0]        radius,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [COORD_BITS:0]    span_row,
	output logic signed [COORD_BITS:0]    span_left,
	output logic signed [COORD_BITS:0]    span_right,
	output logic                          no_pixels,
	output logic                          figure_done,
	output logic                          run_last
);

	localparam int JW = JOB_CTRL_BITS + 2 * COORD_BITS + 2 * WALK_BITS;

	logic                          accept;
	logic                          job_push;
	job_ctrl_t                     job_ctrl;
	logic signed [COORD_BITS-1:0]  job_cx, job_cy;
	logic signed [WALK_BITS-1:0]   job_x, job_y;
	logic [JW-1:0]                 job_data, head;
	logic                          fifo_pop, fifo_empty;

	assign accept = push && !full;

	// Front part: mode register, walk state, classification.
	csog_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.operation (operation),
		.center_x  (center_x),
		.center_y  (center_y),
		.radius    (radius),
		.job_push  (job_push),
		.job_ctrl  (job_ctrl),
		.job_cx    (job_cx),
		.job_cy    (job_cy),
		.job_x     (job_x),
		.job_y     (job_y)
	);

	assign job_data = {job_ctrl, job_cx, job_cy, job_x, job_y};

	// Job queue between the two parts.
	csog_job_fifo #(
		.WIDTH (JW),
		.DEPTH (JOB_FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (job_data),
		.pop    (fifo_pop),
		.rdata  (head),
		.full   (full),
		.empty  (fifo_empty)
	);

	// Back part: result beats into the output register.
	csog_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.fifo_empty  (fifo_empty),
		.head        (head),
		.fifo_pop    (fifo_pop),
		.pop         (pop),
		.empty       (empty),
		.span_row    (span_row),
		.span_left   (span_left),
		.span_right  (span_right),
		.no_pixels   (no_pixels),
		.figure_done (figure_done),
		.run_last    (run_last)
	);

endmodule
